[design/btb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package btb_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W    = 16;
    localparam int EXTENT_W   = 15;
    localparam int SUM_W      = 17;
    localparam int QUO_W      = 16;
    localparam int STEP_W     = 4;
    localparam int IDX_W      = 8;
    localparam int SIZE_W     = 10;
    localparam int GRID_W     = 9;
    localparam int CFG_W      = 10;
    localparam int CFG_ADDR_W = 2;
    localparam int AXIS_W     = 2;

    localparam logic [SIZE_W-1:0] TILE_SIZE_RESET = 10'd32;
    localparam logic [GRID_W-1:0] GRID_RESET      = 9'd64;
    localparam logic [GRID_W-1:0] GRID_MAX        = 9'd256;
    localparam logic [AXIS_W-1:0] AXIS_LAST       = 2'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TILE_WIDTH   = 2'd0,
        CFG_TILE_HEIGHT  = 2'd1,
        CFG_GRID_COLUMNS = 2'd2,
        CFG_GRID_ROWS    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SPAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic             rem_zero;
    } t_div_rsp;

endpackage

`default_nettype wire

[design/btb_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider: one quotient bit per cycle.
module btb_divider #(
    parameter int DIVISOR_W = 14
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire btb_pkg::t_div_req   i_req,
    input  wire  [DIVISOR_W-1:0]     i_divisor,
    output btb_pkg::t_div_rsp        o_rsp
);

    localparam logic [btb_pkg::STEP_W-1:0] LAST_STEP = btb_pkg::STEP_W'(btb_pkg::QUO_W - 1);

    logic [DIVISOR_W-1:0]        r_rem, n_rem;
    logic [btb_pkg::QUO_W-1:0]   r_quo, n_quo;
    logic [btb_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb begin
        trial = {r_rem, r_quo[btb_pkg::QUO_W-1]};
        fits  = (trial >= {1'b0, i_divisor});
        diff  = trial - {1'b0, i_divisor};

        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            n_quo = {r_quo[btb_pkg::QUO_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

[design/box_to_tile_binner.sv]
`timescale 1ns / 1ps
`default_nettype none

// Box to tile binner.
// A box beat (left, top, width, height in signed/unsigned fixed point) enters on the
// box channel when i_box_valid is high and o_box_stall is low. The block then maps
// both corners to tile indices with one shared restoring divider, which runs four
// divisions of 16 steps each, one quotient bit per cycle. After the fourth division
// and a span check the block yields one tile beat per cycle while the receiver does
// not stall, up to MAX_SPAN * MAX_SPAN beats. o_box_stall stays high from acceptance
// until the final tile beat is taken, and the next box can be taken in the cycle
// after that; the block never takes a new box before the last one is done.
// Tile beats come column by column with rows innermost; o_last marks the final one
// and o_truncated is high on every beat of a box whose span was capped.
// While i_tile_stall is high the tile beat holds in the output register unchanged.
// The configuration port writes one register per cycle with i_cfg_we; it is meant
// to be used only while the block is idle. Synchronous reset restores the default
// tile size of 32 by 32 pixels and a 64 by 64 grid and empties the block.
module box_to_tile_binner #(
    parameter int MAX_SPAN      = 8,
    parameter int FRACTION_BITS = 4
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Configuration write port.
    input  wire                               i_cfg_we,
    input  wire  [btb_pkg::CFG_ADDR_W-1:0]    i_cfg_index,
    input  wire  [btb_pkg::CFG_W-1:0]         i_cfg_data,
    // Box channel.
    input  wire                               i_box_valid,
    output logic                              o_box_stall,
    input  wire  signed [btb_pkg::COORD_W-1:0] i_box_left,
    input  wire  signed [btb_pkg::COORD_W-1:0] i_box_top,
    input  wire  [btb_pkg::EXTENT_W-1:0]      i_box_width,
    input  wire  [btb_pkg::EXTENT_W-1:0]      i_box_height,
    // Tile channel.
    output logic                              o_tile_valid,
    input  wire                               i_tile_stall,
    output logic [btb_pkg::IDX_W-1:0]         o_tile_column,
    output logic [btb_pkg::IDX_W-1:0]         o_tile_row,
    output logic                              o_last,
    output logic                              o_truncated
);

    // The divisor is the tile size in fixed point.
    localparam int DIVISOR_W = btb_pkg::SIZE_W + FRACTION_BITS;
    localparam logic [btb_pkg::IDX_W-1:0] SPAN_M1 = btb_pkg::IDX_W'(MAX_SPAN - 1);

    // Configuration registers.
    logic [btb_pkg::SIZE_W-1:0] r_tile_width, r_tile_height;
    logic [btb_pkg::GRID_W-1:0] r_grid_columns, r_grid_rows;

    // Latched box.
    logic signed [btb_pkg::COORD_W-1:0] r_left, r_top;
    logic [btb_pkg::EXTENT_W-1:0]       r_width, r_height;

    // Sequencer and tile walk state.
    btb_pkg::t_state             r_state, n_state;
    logic [btb_pkg::AXIS_W-1:0]  r_axis, n_axis;
    logic [btb_pkg::IDX_W-1:0]   r_column_cursor, n_column_cursor;
    logic [btb_pkg::IDX_W-1:0]   r_row_cursor, n_row_cursor;
    logic [btb_pkg::IDX_W-1:0]   r_first_row, n_first_row;
    logic [btb_pkg::IDX_W-1:0]   r_final_column, n_final_column;
    logic [btb_pkg::IDX_W-1:0]   r_final_row, n_final_row;
    logic                        r_span_capped, n_span_capped;
    logic                        r_out_valid, n_out_valid;

    btb_pkg::t_div_req div_req;
    btb_pkg::t_div_rsp div_rsp;

    logic                          box_beat, tile_beat, at_last;
    logic [btb_pkg::SIZE_W-1:0]    size_sel, size_eff;
    logic [btb_pkg::GRID_W-1:0]    grid_sel;
    logic [btb_pkg::IDX_W-1:0]     lim;
    logic [btb_pkg::COORD_W-1:0]   base_sel;
    logic [btb_pkg::EXTENT_W-1:0]  ext_sel;
    logic [btb_pkg::SUM_W-1:0]     coord;
    logic                          coord_pos;
    logic [btb_pkg::QUO_W-1:0]     q_adj;
    logic [btb_pkg::IDX_W-1:0]     idx;
    logic [DIVISOR_W-1:0]          divisor;
    logic [btb_pkg::IDX_W-1:0]     col_diff, row_diff;

    assign box_beat  = i_box_valid && !o_box_stall;
    assign tile_beat = r_out_valid && !i_tile_stall;
    assign at_last   = (r_column_cursor == r_final_column) && (r_row_cursor == r_final_row);

    // Axis 0 and 2 are columns, 1 and 3 rows; axis 2 and 3 are the far corner.
    always_comb begin
        size_sel = r_axis[0] ? r_tile_height : r_tile_width;
        size_eff = (size_sel == '0) ? btb_pkg::SIZE_W'(1) : size_sel;
        divisor  = DIVISOR_W'(size_eff) << FRACTION_BITS;

        grid_sel = r_axis[0] ? r_grid_rows : r_grid_columns;
        if (grid_sel == '0) begin
            lim = '0;
        end else if (grid_sel > btb_pkg::GRID_MAX) begin
            lim = '1;
        end else begin
            lim = btb_pkg::IDX_W'(grid_sel - 1'b1);
        end

        base_sel  = r_axis[0] ? r_top : r_left;
        ext_sel   = r_axis[1] ? (r_axis[0] ? r_height : r_width) : '0;
        coord     = {base_sel[btb_pkg::COORD_W-1], base_sel} + {2'b00, ext_sel};
        coord_pos = !coord[btb_pkg::SUM_W-1] && (coord != '0);

        // An exact multiple of the tile size belongs to the tile before it.
        q_adj = div_rsp.rem_zero ? (div_rsp.quotient - 1'b1) : div_rsp.quotient;
        if (!coord_pos) begin
            idx = '0;
        end else if (q_adj > btb_pkg::QUO_W'(lim)) begin
            idx = lim;
        end else begin
            idx = q_adj[btb_pkg::IDX_W-1:0];
        end

        div_req.start    = (r_state == btb_pkg::ST_DIV_START);
        div_req.dividend = coord[btb_pkg::QUO_W-1:0];
    end

    btb_divider #(
        .DIVISOR_W (DIVISOR_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_divisor (divisor),
        .o_rsp     (div_rsp)
    );

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state         = r_state;
        n_axis          = r_axis;
        n_column_cursor = r_column_cursor;
        n_row_cursor    = r_row_cursor;
        n_first_row     = r_first_row;
        n_final_column  = r_final_column;
        n_final_row     = r_final_row;
        n_span_capped   = r_span_capped;
        n_out_valid     = r_out_valid;
        col_diff        = r_final_column - r_column_cursor;
        row_diff        = r_final_row - r_first_row;

        case (r_state)
            btb_pkg::ST_IDLE: begin
                if (box_beat) begin
                    n_state       = btb_pkg::ST_DIV_START;
                    n_axis        = '0;
                    n_span_capped = 1'b0;
                end
            end
            btb_pkg::ST_DIV_START: begin
                n_state = btb_pkg::ST_DIV_WAIT;
            end
            btb_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (r_axis)
                        2'd0: n_column_cursor = idx;
                        2'd1: begin
                            n_first_row  = idx;
                            n_row_cursor = idx;
                        end
                        2'd2: n_final_column = idx;
                        default: n_final_row = idx;
                    endcase
                    if (r_axis == btb_pkg::AXIS_LAST) begin
                        n_state = btb_pkg::ST_SPAN;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        n_state = btb_pkg::ST_DIV_START;
                    end
                end
            end
            btb_pkg::ST_SPAN: begin
                // Cap each axis at MAX_SPAN tiles from its start.
                if (col_diff > SPAN_M1) begin
                    n_final_column = r_column_cursor + SPAN_M1;
                    n_span_capped  = 1'b1;
                end
                if (row_diff > SPAN_M1) begin
                    n_final_row   = r_first_row + SPAN_M1;
                    n_span_capped = 1'b1;
                end
                n_out_valid = 1'b1;
                n_state     = btb_pkg::ST_EMIT;
            end
            btb_pkg::ST_EMIT: begin
                if (tile_beat) begin
                    if (at_last) begin
                        n_out_valid = 1'b0;
                        n_state     = btb_pkg::ST_IDLE;
                    end else if (r_row_cursor == r_final_row) begin
                        n_row_cursor    = r_first_row;
                        n_column_cursor = r_column_cursor + 1'b1;
                    end else begin
                        n_row_cursor = r_row_cursor + 1'b1;
                    end
                end
            end
            default: begin
                n_state     = btb_pkg::ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= btb_pkg::ST_IDLE;
            r_axis          <= '0;
            r_column_cursor <= '0;
            r_row_cursor    <= '0;
            r_first_row     <= '0;
            r_final_column  <= '0;
            r_final_row     <= '0;
            r_span_capped   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_axis          <= n_axis;
            r_column_cursor <= n_column_cursor;
            r_row_cursor    <= n_row_cursor;
            r_first_row     <= n_first_row;
            r_final_column  <= n_final_column;
            r_final_row     <= n_final_row;
            r_span_capped   <= n_span_capped;
            r_out_valid     <= n_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width   <= btb_pkg::TILE_SIZE_RESET;
            r_tile_height  <= btb_pkg::TILE_SIZE_RESET;
            r_grid_columns <= btb_pkg::GRID_RESET;
            r_grid_rows    <= btb_pkg::GRID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                btb_pkg::CFG_TILE_WIDTH:   r_tile_width   <= i_cfg_data[btb_pkg::SIZE_W-1:0];
                btb_pkg::CFG_TILE_HEIGHT:  r_tile_height  <= i_cfg_data[btb_pkg::SIZE_W-1:0];
                btb_pkg::CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[btb_pkg::GRID_W-1:0];
                btb_pkg::CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[btb_pkg::GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Box payload is captured on acceptance and held for the whole box.
    always_ff @(posedge i_clk) begin
        if (box_beat) begin
            r_left   <= i_box_left;
            r_top    <= i_box_top;
            r_width  <= i_box_width;
            r_height <= i_box_height;
        end
    end

    assign o_box_stall   = (r_state != btb_pkg::ST_IDLE);
    assign o_tile_valid  = r_out_valid;
    assign o_tile_column = r_column_cursor;
    assign o_tile_row    = r_row_cursor;
    assign o_last        = at_last;
    assign o_truncated   = r_span_capped;

    // A tile beat is only offered while the walk is running.
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tile_valid |-> (r_state == btb_pkg::ST_EMIT))
        else $error("tile beat offered outside the walk");

    // The cursors never pass the final tile of the box.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tile_valid |-> ((o_tile_column <= r_final_column) && (o_tile_row <= r_final_row)
                          && (o_tile_row >= r_first_row)))
        else $error("tile cursor outside the box span");

    // The span on each axis stays within the cap.
    a_span_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tile_valid |-> ((r_final_column - r_column_cursor) <= SPAN_M1)
                         && ((r_final_row - r_first_row) <= SPAN_M1))
        else $error("tile span exceeds the cap");

    // Taking the final tile ends the box and frees the box channel.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tile_beat && o_last) |=> (!o_tile_valid && !o_box_stall))
        else $error("box did not end after its final tile");

    // No new box is taken while a box is in progress.
    a_one_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        box_beat |=> (o_box_stall && !o_tile_valid))
        else $error("box channel open while a box is in progress");

endmodule

`default_nettype wire

[sim/box_to_tile_binner_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the box to tile binner. Boxes are fed beat by beat from a
// queue. Each box the block takes is binned by a behavioral model of the grid,
// which queues the tile beats the block must produce. Every tile beat the bench
// takes is checked against the oldest queued tile.
module box_to_tile_binner_tb;

    localparam int SPAN_CAP      = 8;
    localparam int FRAC_BITS     = 4;
    // A box is four divisions plus up to 64 tile beats, each of which may wait out a stall.
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic [btb_pkg::COORD_W-1:0]  left;
        logic [btb_pkg::COORD_W-1:0]  top;
        logic [btb_pkg::EXTENT_W-1:0] width;
        logic [btb_pkg::EXTENT_W-1:0] height;
    } t_box;

    typedef struct packed {
        logic [btb_pkg::IDX_W-1:0] column;
        logic [btb_pkg::IDX_W-1:0] row;
        logic                      last;
        logic                      truncated;
    } t_tile;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every block input starts at a known value.
    logic                           cfg_we    = 1'b0;
    logic [btb_pkg::CFG_ADDR_W-1:0] cfg_index = btb_pkg::CFG_TILE_WIDTH;
    logic [btb_pkg::CFG_W-1:0]      cfg_data  = '0;

    logic                           box_valid  = 1'b0;
    logic [btb_pkg::COORD_W-1:0]    box_left   = '0;
    logic [btb_pkg::COORD_W-1:0]    box_top    = '0;
    logic [btb_pkg::EXTENT_W-1:0]   box_width  = '0;
    logic [btb_pkg::EXTENT_W-1:0]   box_height = '0;
    logic                           tile_stall = 1'b0;

    wire                            box_stall;
    wire                            tile_valid;
    wire [btb_pkg::IDX_W-1:0]       tile_column;
    wire [btb_pkg::IDX_W-1:0]       tile_row;
    wire                            tile_last;
    wire                            tile_truncated;

    box_to_tile_binner #(
        .MAX_SPAN      (SPAN_CAP),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_box_valid   (box_valid),
        .o_box_stall   (box_stall),
        .i_box_left    (box_left),
        .i_box_top     (box_top),
        .i_box_width   (box_width),
        .i_box_height  (box_height),
        .o_tile_valid  (tile_valid),
        .i_tile_stall  (tile_stall),
        .o_tile_column (tile_column),
        .o_tile_row    (tile_row),
        .o_last        (tile_last),
        .o_truncated   (tile_truncated)
    );

    // Shadow copy of the grid registers, as the block holds them after reset.
    logic [btb_pkg::SIZE_W-1:0] tile_w_cfg    = btb_pkg::TILE_SIZE_RESET;
    logic [btb_pkg::SIZE_W-1:0] tile_h_cfg    = btb_pkg::TILE_SIZE_RESET;
    logic [btb_pkg::GRID_W-1:0] grid_cols_cfg = btb_pkg::GRID_RESET;
    logic [btb_pkg::GRID_W-1:0] grid_rows_cfg = btb_pkg::GRID_RESET;

    t_box  box_queue[$];       // boxes waiting to be sent
    t_tile tiles_pending[$];   // tiles the block still owes us

    // When set, neither side idles: long back-to-back stretches.
    bit steady = 1'b0;

    int    send_gap      = 0;
    int    hold_left     = 0;
    int    stall_draw    = 0;
    int    cycles        = 0;
    int    boxes_taken   = 0;
    int    tiles_checked = 0;
    int    capped_boxes  = 0;
    int    configs_run   = 0;
    int    mismatches    = 0;
    t_box  next_box;
    t_tile want;

    initial begin
        forever #1 clk = ~clk;
    end

    // Append one box to the send queue.
    task automatic queue_box(input t_box b);
        box_queue.insert(box_queue.size(), b);
    endtask

    // Map one fixed-point coordinate onto a tile index of one axis. A coordinate that
    // sits exactly on a tile boundary belongs to the tile before it, anything at or
    // below zero lands in tile 0, and the result never leaves the grid.
    function automatic int unsigned tile_of(int c, int unsigned size, int unsigned grid);
        int unsigned pitch;
        int unsigned top_idx;
        int unsigned q;
        pitch = (size == 0) ? 1 : size;
        pitch = pitch << FRAC_BITS;
        if (grid == 0)
            top_idx = 0;
        else if (grid > btb_pkg::GRID_MAX)
            top_idx = btb_pkg::GRID_MAX - 1;
        else
            top_idx = grid - 1;
        if (c <= 0)
            return 0;
        q = c / pitch;
        if (c % pitch == 0)
            q = q - 1;
        return (q > top_idx) ? top_idx : q;
    endfunction

    // Work out every tile a box covers, column by column with rows innermost, and
    // queue them. Each axis is capped at SPAN_CAP tiles, which flags every tile.
    task automatic bin_box(input t_box b);
        int    l;
        int    t;
        int    c0;
        int    c1;
        int    r0;
        int    r1;
        bit    capped;
        t_tile tl;
        l  = int'($signed(b.left));
        t  = int'($signed(b.top));
        c0 = tile_of(l, tile_w_cfg, grid_cols_cfg);
        c1 = tile_of(l + int'(b.width), tile_w_cfg, grid_cols_cfg);
        r0 = tile_of(t, tile_h_cfg, grid_rows_cfg);
        r1 = tile_of(t + int'(b.height), tile_h_cfg, grid_rows_cfg);
        capped = 1'b0;
        if (c1 - c0 + 1 > SPAN_CAP) begin
            c1 = c0 + SPAN_CAP - 1;
            capped = 1'b1;
        end
        if (r1 - r0 + 1 > SPAN_CAP) begin
            r1 = r0 + SPAN_CAP - 1;
            capped = 1'b1;
        end
        for (int c = c0; c <= c1; c++) begin
            for (int r = r0; r <= r1; r++) begin
                tl.column    = btb_pkg::IDX_W'(c);
                tl.row       = btb_pkg::IDX_W'(r);
                tl.last      = (c == c1) && (r == r1);
                tl.truncated = capped;
                tiles_pending.insert(tiles_pending.size(), tl);
            end
        end
        if (capped)
            capped_boxes++;
    endtask

    // Box driver. A beat the block has not taken yet holds still; once it is taken,
    // the box is binned and the next one goes out after a random gap.
    always @(posedge clk) begin
        if (!rst_n) begin
            box_valid <= 1'b0;
            send_gap  <= 0;
        end else if (box_valid && box_stall !== 1'b0) begin
            // The block is stalling the beat, so the payload stays as it is.
        end else begin
            if (box_valid) begin
                bin_box({box_left, box_top, box_width, box_height});
                boxes_taken++;
            end
            if (send_gap != 0) begin
                box_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (box_queue.size() != 0) begin
                next_box   = box_queue.pop_front();
                box_left   <= next_box.left;
                box_top    <= next_box.top;
                box_width  <= next_box.width;
                box_height <= next_box.height;
                box_valid  <= 1'b1;
                send_gap   <= steady ? 0 : $urandom_range(0, 8);
            end else begin
                box_valid <= 1'b0;
            end
        end
    end

    // Tile monitor. Each taken beat is compared with the oldest pending tile, then the
    // receiver may stall at random. While no tile is on offer it also stalls now and
    // then, so the first beat of a box can meet a stall as well.
    always @(posedge clk) begin
        if (!rst_n) begin
            tile_stall <= 1'b0;
            hold_left  <= 0;
        end else begin
            if (tile_valid === 1'b1 && !tile_stall) begin
                tiles_checked++;
                if (tiles_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected tile beat: column %0d row %0d last %b trunc %b",
                                 tile_column, tile_row, tile_last, tile_truncated);
                end else begin
                    want = tiles_pending.pop_front();
                    if (tile_column !== want.column || tile_row !== want.row ||
                        tile_last !== want.last || tile_truncated !== want.truncated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tile mismatch: want %0d,%0d l%b t%b got %0d,%0d l%b t%b",
                                     want.column, want.row, want.last, want.truncated,
                                     tile_column, tile_row, tile_last, tile_truncated);
                    end
                end
                stall_draw = steady ? 0 : $urandom_range(0, 8);
                hold_left  <= stall_draw;
                tile_stall <= (stall_draw != 0);
            end else if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                tile_stall <= (hold_left > 1);
            end else begin
                tile_stall <= !steady && ($urandom_range(0, 15) == 0);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("box_to_tile_binner_tb: done, errors");
            $finish;
        end
    end

    // Wait until every queued box has been taken and every tile it owes has arrived.
    task automatic drain();
        do
            @(negedge clk);
        while (box_queue.size() != 0 || box_valid || tiles_pending.size() != 0);
    endtask

    // Write all four grid registers, one per cycle, while the block is idle. The
    // shadow copy keeps only the bits each register holds.
    task automatic set_config(input logic [btb_pkg::CFG_W-1:0] tw,
                              input logic [btb_pkg::CFG_W-1:0] th,
                              input logic [btb_pkg::CFG_W-1:0] gc,
                              input logic [btb_pkg::CFG_W-1:0] gr);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= btb_pkg::CFG_TILE_WIDTH;
        cfg_data  <= tw;
        tile_w_cfg = tw[btb_pkg::SIZE_W-1:0];
        @(posedge clk);
        cfg_index <= btb_pkg::CFG_TILE_HEIGHT;
        cfg_data  <= th;
        tile_h_cfg = th[btb_pkg::SIZE_W-1:0];
        @(posedge clk);
        cfg_index <= btb_pkg::CFG_GRID_COLUMNS;
        cfg_data  <= gc;
        grid_cols_cfg = gc[btb_pkg::GRID_W-1:0];
        @(posedge clk);
        cfg_index <= btb_pkg::CFG_GRID_ROWS;
        cfg_data  <= gr;
        grid_rows_cfg = gr[btb_pkg::GRID_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        configs_run++;
    endtask

    // Queue random boxes shaped by the current grid. Most are placed inside the
    // grid with spans of a few tiles; some snap to tile boundaries, give or take one
    // fraction step; the rest are raw noise that reaches every field bit.
    task automatic queue_random(input int n);
        int   kind;
        int   pitch_x;
        int   pitch_y;
        int   reach_x;
        int   reach_y;
        int   lx;
        int   ty;
        int   wx;
        int   hy;
        t_box b;
        pitch_x = (tile_w_cfg == 0) ? 1 : int'(tile_w_cfg);
        pitch_y = (tile_h_cfg == 0) ? 1 : int'(tile_h_cfg);
        pitch_x = pitch_x << FRAC_BITS;
        pitch_y = pitch_y << FRAC_BITS;
        reach_x = (grid_cols_cfg == 0) ? 1 : (grid_cols_cfg > btb_pkg::GRID_MAX) ? 256 :
                  int'(grid_cols_cfg);
        reach_y = (grid_rows_cfg == 0) ? 1 : (grid_rows_cfg > btb_pkg::GRID_MAX) ? 256 :
                  int'(grid_rows_cfg);
        reach_x = reach_x * pitch_x;
        reach_y = reach_y * pitch_y;
        if (reach_x > 32767)
            reach_x = 32767;
        if (reach_y > 32767)
            reach_y = 32767;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                lx = int'($urandom_range(0, 65535));
                ty = int'($urandom_range(0, 65535));
                wx = int'($urandom_range(0, 32767));
                hy = int'($urandom_range(0, 32767));
            end else if (kind <= 2) begin
                lx = pitch_x * int'($urandom_range(0, 9)) + int'($urandom_range(0, 2)) - 1;
                ty = pitch_y * int'($urandom_range(0, 9)) + int'($urandom_range(0, 2)) - 1;
                wx = pitch_x * int'($urandom_range(0, 9)) + int'($urandom_range(0, 2)) - 1;
                hy = pitch_y * int'($urandom_range(0, 9)) + int'($urandom_range(0, 2)) - 1;
            end else begin
                lx = int'($urandom_range(0, reach_x)) - int'($urandom_range(0, pitch_x));
                ty = int'($urandom_range(0, reach_y)) - int'($urandom_range(0, pitch_y));
                wx = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, pitch_x * 10))
                                                 : int'($urandom_range(0, pitch_x * 3));
                hy = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, pitch_y * 10))
                                                 : int'($urandom_range(0, pitch_y * 3));
            end
            if (wx < 0)
                wx = 0;
            if (hy < 0)
                hy = 0;
            b.left   = btb_pkg::COORD_W'(lx);
            b.top    = btb_pkg::COORD_W'(ty);
            b.width  = btb_pkg::EXTENT_W'(wx);
            b.height = btb_pkg::EXTENT_W'(hy);
            queue_box(b);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed boxes on the reset grid: 32 by 32 pixel tiles, 64 by 64 of them,
        // so one tile is 512 in fixed point.
        @(negedge clk);
        queue_box(t_box'{16'h0000, 16'h0000, 15'h0000, 15'h0000});
        queue_box(t_box'{16'h8000, 16'h8000, 15'h0000, 15'h0000});
        queue_box(t_box'{16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF});
        queue_box(t_box'{16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF});
        // Corners exactly on a tile boundary fall back one tile.
        queue_box(t_box'{16'd512, 16'd512, 15'd0, 15'd0});
        queue_box(t_box'{16'd513, 16'd513, 15'd0, 15'd0});
        queue_box(t_box'{16'd0, 16'd0, 15'd512, 15'd512});
        queue_box(t_box'{16'd0, 16'd0, 15'd513, 15'd513});
        // A full 8 by 8 span, then one fraction step more on either axis or both.
        queue_box(t_box'{16'd0, 16'd0, 15'd4096, 15'd4096});
        queue_box(t_box'{16'd0, 16'd0, 15'd4097, 15'd4097});
        queue_box(t_box'{16'd0, 16'd0, 15'd4097, 15'd0});
        queue_box(t_box'{16'd0, 16'd0, 15'd0, 15'd4097});
        queue_box(t_box'{16'd100, 16'hFFCE, 15'd2000, 15'd300});
        queue_box(t_box'{16'hFFFF, 16'hFFFF, 15'd1, 15'd1});
        queue_box(t_box'{16'd1, 16'd1, 15'd0, 15'd0});
        // Near the far edge of the grid the end index is clamped.
        queue_box(t_box'{16'd32000, 16'd100, 15'h7FFF, 15'd0});
        queue_box(t_box'{16'h7FFF, 16'h8000, 15'h0000, 15'h7FFF});
        drain();

        // Smallest tiles on the largest grid: indices clamp at 255.
        set_config(10'd1, 10'd1, 10'd256, 10'd256);
        @(negedge clk);
        queue_random(55);
        drain();

        // Largest tiles on a one-tile grid, with no idling on either side.
        set_config(10'd1023, 10'd1023, 10'd1, 10'd1);
        @(negedge clk);
        steady = 1'b1;
        queue_random(50);
        drain();
        steady = 1'b0;

        // Zero sizes behave as one pixel tiles on a one-tile grid.
        set_config(10'd0, 10'd0, 10'd0, 10'd0);
        @(negedge clk);
        queue_box(t_box'{16'd0, 16'd0, 15'd0, 15'd0});
        queue_box(t_box'{16'd16, 16'd16, 15'd16, 15'd16});
        queue_box(t_box'{16'd17, 16'd17, 15'd1, 15'd1});
        queue_random(40);
        drain();

        // Grid registers above 256 act as 256.
        set_config(10'd16, 10'd8, 10'd511, 10'd300);
        @(negedge clk);
        queue_random(55);
        drain();

        // Odd sizes. Halfway through, the sender waits until every tile is in.
        set_config(10'd7, 10'd13, 10'd20, 10'd9);
        @(negedge clk);
        queue_random(30);
        drain();
        queue_random(30);
        drain();

        // Two fully random settings, all ten data bits included.
        repeat (2) begin
            set_config(btb_pkg::CFG_W'($urandom_range(0, 1023)),
                       btb_pkg::CFG_W'($urandom_range(0, 1023)),
                       btb_pkg::CFG_W'($urandom_range(0, 1023)),
                       btb_pkg::CFG_W'($urandom_range(0, 1023)));
            @(negedge clk);
            queue_random(60);
            drain();
        end

        // Back to the reset values, written explicitly this time.
        set_config(10'd32, 10'd32, 10'd64, 10'd64);
        @(negedge clk);
        queue_random(70);
        drain();

        // Give a stray extra beat time to show up before closing.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tiles_pending.size() != 0)
            mismatches = mismatches + tiles_pending.size();

        $display("Binned %0d boxes into %0d tile beats over %0d written grid settings;",
                 boxes_taken, tiles_checked, configs_run);
        $display("%0d boxes hit the span cap, %0d mismatches.", capped_boxes, mismatches);
        if (mismatches == 0) begin
            $display("box_to_tile_binner_tb: done, clean");
        end else begin
            $display("box_to_tile_binner_tb: done, errors");
        end
        $finish;
    end

endmodule
